>>> hw/rtl/gwm_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package gwm_pkg;

    localparam int CAPACITY    = 128;
    localparam int POS_W       = $clog2(CAPACITY + 1);
    localparam int IDX_W       = $clog2(CAPACITY);
    localparam int CLOSE_STEPS = $clog2(CAPACITY + 1);
    localparam int CHAR_W      = 8;

    localparam logic [CHAR_W-1:0] CHAR_STAR = 8'h2A;
    localparam logic [CHAR_W-1:0] CHAR_ANY  = 8'h3F;
    localparam logic [CHAR_W-1:0] CHAR_END  = 8'h00;

    localparam logic OP_PATTERN = 1'b0;
    localparam logic OP_NAME    = 1'b1;

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic [CAPACITY:0] ACTIVE_START = {{CAPACITY{1'b0}}, 1'b1};

    // One classified beat as it travels from the front end to the engine.
    typedef struct packed {
        logic              is_name;
        logic              add_char;
        logic              last;
        logic              is_star;
        logic              is_any;
        logic [CHAR_W-1:0] code;
    } t_cmd;

endpackage

`default_nettype wire

>>> hw/rtl/gwm_front.sv
`timescale 1ns / 1ps
`default_nettype none

module gwm_front (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    output logic                    o_in_stall,
    input  wire logic               i_operation,
    input  wire logic [7:0]         i_char_code,
    input  wire logic               i_last,
    input  wire logic               i_q_full,
    output logic                    o_push,
    output gwm_pkg::t_cmd           o_cmd
);

    logic          r_valid;
    logic          n_valid;
    gwm_pkg::t_cmd r_cmd;
    gwm_pkg::t_cmd n_cmd;
    logic          load;

    assign o_in_stall = r_valid & i_q_full;
    assign load       = i_in_valid & ~o_in_stall;
    assign o_push     = r_valid & ~i_q_full;
    assign o_cmd      = r_cmd;

    always_comb begin
        n_cmd.is_name  = (i_operation == gwm_pkg::OP_NAME);
        // A zero byte with the last flag closes the stream without a character.
        n_cmd.add_char = ~(i_last & (i_char_code == gwm_pkg::CHAR_END));
        n_cmd.last     = i_last;
        n_cmd.is_star  = (i_char_code == gwm_pkg::CHAR_STAR);
        n_cmd.is_any   = (i_char_code == gwm_pkg::CHAR_ANY);
        n_cmd.code     = i_char_code;
    end

    always_comb begin
        if (load) begin
            n_valid = 1'b1;
        end else if (o_push) begin
            n_valid = 1'b0;
        end else begin
            n_valid = r_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_cmd <= n_cmd;
        end
    end

endmodule

`default_nettype wire

>>> hw/rtl/gwm_queue.sv
`timescale 1ns / 1ps
`default_nettype none

module gwm_queue (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_push,
    input  wire gwm_pkg::t_cmd i_cmd,
    output logic               o_full,
    input  wire logic          i_pop,
    output logic               o_empty,
    output gwm_pkg::t_cmd      o_head
);

    gwm_pkg::t_cmd                  r_slot [gwm_pkg::QUEUE_DEPTH];
    logic [gwm_pkg::QPTR_W-1:0]     r_wr_ptr;
    logic [gwm_pkg::QPTR_W-1:0]     r_rd_ptr;
    logic [gwm_pkg::QCNT_W-1:0]     r_count;
    logic [gwm_pkg::QPTR_W-1:0]     n_wr_ptr;
    logic [gwm_pkg::QPTR_W-1:0]     n_rd_ptr;
    logic [gwm_pkg::QCNT_W-1:0]     n_count;
    logic                           do_push;
    logic                           do_pop;

    assign o_full  = (r_count == gwm_pkg::QCNT_W'(gwm_pkg::QUEUE_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_head  = r_slot[r_rd_ptr];
    assign do_push = i_push & ~o_full;
    assign do_pop  = i_pop & ~o_empty;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (do_push) begin
            if (r_wr_ptr == gwm_pkg::QPTR_W'(gwm_pkg::QUEUE_DEPTH - 1)) begin
                n_wr_ptr = '0;
            end else begin
                n_wr_ptr = r_wr_ptr + gwm_pkg::QPTR_W'(1);
            end
        end
        if (do_pop) begin
            if (r_rd_ptr == gwm_pkg::QPTR_W'(gwm_pkg::QUEUE_DEPTH - 1)) begin
                n_rd_ptr = '0;
            end else begin
                n_rd_ptr = r_rd_ptr + gwm_pkg::QPTR_W'(1);
            end
        end
        if (do_push && !do_pop) begin
            n_count = r_count + gwm_pkg::QCNT_W'(1);
        end else if (do_pop && !do_push) begin
            n_count = r_count - gwm_pkg::QCNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_slot[r_wr_ptr] <= i_cmd;
        end
    end

endmodule

`default_nettype wire

>>> hw/rtl/gwm_back.sv
`timescale 1ns / 1ps
`default_nettype none

module gwm_back (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_empty,
    input  wire gwm_pkg::t_cmd i_head,
    output logic               o_pop,
    output logic               o_out_valid,
    input  wire logic          i_out_stall,
    output logic               o_match,
    output logic               o_pattern_overflow
);

    // Pattern cells: one character and its wildcard flags per position.
    logic [gwm_pkg::CHAR_W-1:0]   r_code [gwm_pkg::CAPACITY];
    logic [gwm_pkg::CAPACITY-1:0] r_star;
    logic [gwm_pkg::CAPACITY-1:0] r_any;

    // Control state.
    logic [gwm_pkg::CAPACITY-1:0] r_mask;
    logic [gwm_pkg::CAPACITY-1:0] n_mask;
    logic [gwm_pkg::POS_W-1:0]    r_len;
    logic [gwm_pkg::POS_W-1:0]    n_len;
    logic [gwm_pkg::CAPACITY:0]   r_active;
    logic [gwm_pkg::CAPACITY:0]   n_active;
    logic                         r_ovf;
    logic                         n_ovf;
    logic                         r_done;
    logic                         n_done;
    logic                         r_out_valid;
    logic                         n_out_valid;
    logic                         r_match;
    logic                         r_out_ovf;

    logic                         out_free;
    logic                         result;
    logic                         wr_en;
    logic [gwm_pkg::IDX_W-1:0]    wr_idx;
    logic [gwm_pkg::POS_W-1:0]    base_len;
    logic [gwm_pkg::CAPACITY-1:0] base_mask;
    logic                         room;
    logic [gwm_pkg::CAPACITY:0]   prop;
    logic [gwm_pkg::CAPACITY:0]   closed_cur;
    logic [gwm_pkg::CAPACITY-1:0] stay;
    logic [gwm_pkg::CAPACITY-1:0] hit;
    logic [gwm_pkg::CAPACITY:0]   after_char;
    logic [gwm_pkg::CAPACITY:0]   closed_end;
    logic                         match_now;

    // Star closure as a parallel prefix: a position is reached if some active
    // position below it is joined to it by an unbroken run of stored stars.
    function automatic logic [gwm_pkg::CAPACITY:0] close_vec(
        input logic [gwm_pkg::CAPACITY:0] act,
        input logic [gwm_pkg::CAPACITY:0] prp
    );
        logic [gwm_pkg::CAPACITY:0] g;
        logic [gwm_pkg::CAPACITY:0] p;
        logic [gwm_pkg::CAPACITY:0] g_n;
        logic [gwm_pkg::CAPACITY:0] p_n;
        int                         d;
        g = act;
        p = prp;
        for (int s = 0; s < gwm_pkg::CLOSE_STEPS; s++) begin
            d = 1 << s;
            for (int j = 0; j <= gwm_pkg::CAPACITY; j++) begin
                if (j >= d) begin
                    g_n[j] = g[j] | (p[j] & g[j-d]);
                    p_n[j] = p[j] & p[j-d];
                end else begin
                    g_n[j] = g[j];
                    p_n[j] = 1'b0;
                end
            end
            g = g_n;
            p = p_n;
        end
        return g;
    endfunction

    assign out_free = ~r_out_valid | ~i_out_stall;
    assign o_pop    = ~i_empty & out_free;
    assign result   = o_pop & i_head.is_name & i_head.last;

    assign o_out_valid        = r_out_valid;
    assign o_match            = r_match;
    assign o_pattern_overflow = r_out_ovf;

    // prop[j] lets the closure step from position j-1 into position j.
    assign prop = {r_star & r_mask, 1'b0};

    always_comb begin
        closed_cur = close_vec(r_active, prop);
        for (int i = 0; i < gwm_pkg::CAPACITY; i++) begin
            stay[i] = closed_cur[i] & r_mask[i] & r_star[i];
            hit[i]  = closed_cur[i] & r_mask[i] & ~r_star[i]
                      & (r_any[i] | (r_code[i] == i_head.code));
        end
        after_char = i_head.add_char ? ({hit, 1'b0} | {1'b0, stay}) : r_active;
        closed_end = close_vec(after_char, prop);
        match_now  = closed_end[r_len];
    end

    // A pattern beat that follows a finished pattern starts a fresh one.
    assign base_len  = r_done ? '0 : r_len;
    assign base_mask = r_done ? '0 : r_mask;
    assign room      = ~base_mask[gwm_pkg::CAPACITY-1];
    assign wr_en     = o_pop & ~i_head.is_name & i_head.add_char & room;
    assign wr_idx    = base_len[gwm_pkg::IDX_W-1:0];

    always_comb begin
        n_len    = r_len;
        n_mask   = r_mask;
        n_ovf    = r_ovf;
        n_done   = r_done;
        n_active = r_active;
        if (o_pop) begin
            if (!i_head.is_name) begin
                n_len  = base_len;
                n_mask = base_mask;
                n_ovf  = r_ovf & ~r_done;
                if (i_head.add_char) begin
                    if (room) begin
                        n_len  = base_len + gwm_pkg::POS_W'(1);
                        n_mask = {base_mask[gwm_pkg::CAPACITY-2:0], 1'b1};
                    end else begin
                        n_ovf = 1'b1;
                    end
                end
                n_done = i_head.last;
                if (r_done || i_head.last) begin
                    n_active = gwm_pkg::ACTIVE_START;
                end
            end else if (i_head.last) begin
                n_active = gwm_pkg::ACTIVE_START;
            end else begin
                n_active = after_char;
            end
        end
    end

    always_comb begin
        if (result) begin
            n_out_valid = 1'b1;
        end else if (!i_out_stall) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len       <= '0;
            r_mask      <= '0;
            r_ovf       <= 1'b0;
            r_done      <= 1'b1;
            r_active    <= gwm_pkg::ACTIVE_START;
            r_out_valid <= 1'b0;
        end else begin
            r_len       <= n_len;
            r_mask      <= n_mask;
            r_ovf       <= n_ovf;
            r_done      <= n_done;
            r_active    <= n_active;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_code[wr_idx] <= i_head.code;
            r_star[wr_idx] <= i_head.is_star;
            r_any[wr_idx]  <= i_head.is_any;
        end
        if (result) begin
            r_match   <= match_now;
            r_out_ovf <= r_ovf;
        end
    end

endmodule

`default_nettype wire

>>> hw/rtl/glob_wildcard_matcher.sv
// Wildcard glob matcher: '*' matches any run of characters, '?' exactly one.
// Input channel (i_in_valid / o_in_stall): one beat per character. With
// i_operation = 0 the beat appends to the stored pattern (up to 128 chars,
// extra ones are dropped and flagged); with i_operation = 1 it is a name
// character. i_last marks the final beat of a pattern or name; a zero byte
// with i_last ends it without adding a character.
// Output channel (o_out_valid / i_out_stall): one beat per finished name,
// carrying o_match and o_pattern_overflow. Pattern beats give no output.
// Throughput is one beat per cycle while the output is not stalled: every
// pattern position is updated in parallel in the matching engine for each
// character. A name's last beat is loaded into the front register when it is
// accepted, then passes through a queue slot and into the output register.
// When the receiver stalls, the result holds in the output register; the
// engine waits, the queue fills and then the input channel stalls.
// Reset clears the stored pattern to empty, so only an empty name matches
// until a pattern is loaded; it takes effect at once, with no clearing pass.
`timescale 1ns / 1ps
`default_nettype none

module glob_wildcard_matcher (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_in_valid,
    output logic            o_in_stall,
    input  wire logic       i_operation,
    input  wire logic [7:0] i_char_code,
    input  wire logic       i_last,
    output logic            o_out_valid,
    input  wire logic       i_out_stall,
    output logic            o_match,
    output logic            o_pattern_overflow
);

    gwm_pkg::t_cmd push_cmd;
    gwm_pkg::t_cmd head_cmd;
    logic          push;
    logic          q_full;
    logic          q_empty;
    logic          pop;

    gwm_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_operation (i_operation),
        .i_char_code (i_char_code),
        .i_last      (i_last),
        .i_q_full    (q_full),
        .o_push      (push),
        .o_cmd       (push_cmd)
    );

    gwm_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (push_cmd),
        .o_full  (q_full),
        .i_pop   (pop),
        .o_empty (q_empty),
        .o_head  (head_cmd)
    );

    gwm_back u_back (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_empty            (q_empty),
        .i_head             (head_cmd),
        .o_pop              (pop),
        .o_out_valid        (o_out_valid),
        .i_out_stall        (i_out_stall),
        .o_match            (o_match),
        .o_pattern_overflow (o_pattern_overflow)
    );

endmodule

`default_nettype wire

>>> hw/rtl/gwm_checker.sv
`timescale 1ns / 1ps
`default_nettype none

module gwm_checker (
    input wire logic       i_clk,
    input wire logic       i_rst_n,
    input wire logic       o_in_stall,
    input wire logic       o_out_valid,
    input wire logic       i_out_stall,
    input wire logic       o_match,
    input wire logic       o_pattern_overflow
);

    // A stalled result beat stays offered.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid)
        else $error("result beat dropped while stalled");

    // A stalled result beat keeps its payload.
    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> $stable(o_match) && $stable(o_pattern_overflow))
        else $error("result payload changed while stalled");

    // Nothing is pending right after reset, so input is taken at once.
    a_reset_ready: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_in_stall)
        else $error("input stalled right after reset");

    // A result passes three register stages, so none is offered just after reset.
    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid ##1 !o_out_valid ##1 !o_out_valid)
        else $error("result appeared too soon after reset");

endmodule

bind glob_wildcard_matcher gwm_checker u_gwm_checker (.*);

`default_nettype wire

>>> test/tb.sv
`timescale 1ns / 1ps

module tb;

    localparam int BEAT_TARGET = 1800;
    localparam int LONG_HOLD   = 150;
    localparam int STALL_LIMIT = 2000;
    localparam int SETTLE      = 8;

    typedef struct packed {
        bit match;
        bit overflow;
    } t_verdict;

    typedef logic [7:0] t_char_q [$];

    // Tracks the stored pattern and the live NFA positions, and keeps the
    // verdicts that finished names are owed, oldest first.
    class t_scoreboard;
        logic [7:0]               pattern_chars [gwm_pkg::CAPACITY];
        int unsigned              pattern_len    = 0;
        bit [gwm_pkg::CAPACITY:0] live_pos       = gwm_pkg::ACTIVE_START;
        bit                       overflow_seen  = 1'b0;
        bit                       pattern_closed = 1'b1;
        t_verdict                 pending_verdicts [$];
        int                       errors         = 0;
        int                       verdicts_seen  = 0;
        int                       match_count    = 0;
        int                       overflow_count = 0;

        function bit [gwm_pkg::CAPACITY:0] star_closure(bit [gwm_pkg::CAPACITY:0] v);
            for (int i = 0; i < pattern_len; i++) begin
                if (v[i] && pattern_chars[i] == gwm_pkg::CHAR_STAR) v[i+1] = 1'b1;
            end
            return v;
        endfunction

        function void take_beat(logic op, logic [7:0] code, logic lst);
            bit                       end_only;
            bit [gwm_pkg::CAPACITY:0] reach;
            t_verdict                 v;
            end_only = lst && code == gwm_pkg::CHAR_END;
            if (op == gwm_pkg::OP_PATTERN) begin
                if (pattern_closed) begin
                    pattern_len    = 0;
                    overflow_seen  = 1'b0;
                    pattern_closed = 1'b0;
                    live_pos       = gwm_pkg::ACTIVE_START;
                end
                if (!end_only) begin
                    if (pattern_len < gwm_pkg::CAPACITY) begin
                        pattern_chars[pattern_len] = code;
                        pattern_len++;
                    end else begin
                        overflow_seen = 1'b1;
                    end
                end
                if (lst) begin
                    pattern_closed = 1'b1;
                    live_pos       = gwm_pkg::ACTIVE_START;
                end
                return;
            end
            if (!end_only) begin
                reach    = star_closure(live_pos);
                live_pos = '0;
                for (int i = 0; i < pattern_len; i++) begin
                    if (reach[i]) begin
                        if (pattern_chars[i] == gwm_pkg::CHAR_STAR) begin
                            live_pos[i] = 1'b1;
                        end else if (pattern_chars[i] == gwm_pkg::CHAR_ANY
                                     || pattern_chars[i] == code) begin
                            live_pos[i+1] = 1'b1;
                        end
                    end
                end
            end
            if (lst) begin
                reach      = star_closure(live_pos);
                v.match    = reach[pattern_len];
                v.overflow = overflow_seen;
                pending_verdicts.push_back(v);
                live_pos = gwm_pkg::ACTIVE_START;
            end
        endfunction

        task report(string msg);
            $display("MISMATCH: %s", msg);
            errors++;
        endtask

        task check_result(logic m, logic o);
            t_verdict v;
            if (pending_verdicts.size() == 0) begin
                report($sformatf("result match=%b overflow=%b with no name pending", m, o));
                return;
            end
            v = pending_verdicts.pop_front();
            verdicts_seen++;
            if (v.match) match_count++;
            if (v.overflow) overflow_count++;
            if (m !== v.match)
                report($sformatf("verdict %0d: match %b, expected %b", verdicts_seen, m, v.match));
            if (o !== v.overflow)
                report($sformatf("verdict %0d: overflow %b, expected %b",
                                 verdicts_seen, o, v.overflow));
        endtask
    endclass

    logic       i_clk        = 1'b0;
    logic       i_rst_n      = 1'b0;
    logic       i_in_valid   = 1'b0;
    logic       i_operation  = 1'b0;
    logic [7:0] i_char_code  = 8'h00;
    logic       i_last       = 1'b0;
    logic       i_out_stall  = 1'b0;
    logic       hold_req     = 1'b0;
    logic       o_in_stall;
    logic       o_out_valid;
    logic       o_match;
    logic       o_pattern_overflow;

    t_scoreboard sb = new;
    int          beats_sent = 0;
    bit          calm_in    = 1'b0;
    bit          calm_out   = 1'b0;

    glob_wildcard_matcher u_top (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_in_valid         (i_in_valid),
        .o_in_stall         (o_in_stall),
        .i_operation        (i_operation),
        .i_char_code        (i_char_code),
        .i_last             (i_last),
        .o_out_valid        (o_out_valid),
        .i_out_stall        (i_out_stall),
        .o_match            (o_match),
        .o_pattern_overflow (o_pattern_overflow)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // Called at a rising edge; returns at the edge where the beat is taken.
    task automatic send_beat(logic op, logic [7:0] code, logic lst);
        int gap;
        if ($urandom_range(0, 59) == 0) calm_in = !calm_in;
        gap = calm_in ? 0 : $urandom_range(0, 4);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid  <= 1'b1;
        i_operation <= op;
        i_char_code <= code;
        i_last      <= lst;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        sb.take_beat(op, code, lst);
        beats_sent++;
    endtask

    // A trailing zero byte would read as the end marker, so such a run is
    // always closed by an explicit marker beat.
    task automatic send_seq(logic op, t_char_q s);
        bit marker;
        marker = s.size() == 0 || s[s.size()-1] == gwm_pkg::CHAR_END
                 || $urandom_range(0, 1) == 1;
        foreach (s[i]) send_beat(op, s[i], !marker && i == s.size() - 1);
        if (marker) send_beat(op, gwm_pkg::CHAR_END, 1'b1);
    endtask

    task automatic drain_results();
        i_in_valid <= 1'b0;
        while (sb.pending_verdicts.size() > 0) @(posedge i_clk);
    endtask

    function automatic logic [7:0] pattern_char();
        case ($urandom_range(0, 9))
            0, 1, 2: return "a";
            3:       return "b";
            4, 5:    return gwm_pkg::CHAR_STAR;
            6:       return gwm_pkg::CHAR_ANY;
            7:       return gwm_pkg::CHAR_END;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    function automatic logic [7:0] name_char();
        case ($urandom_range(0, 9))
            0, 1, 2: return "a";
            3, 4, 5: return "b";
            6:       return gwm_pkg::CHAR_END;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    function automatic t_char_q make_pattern(int n);
        t_char_q s;
        repeat (n) s.push_back(pattern_char());
        return s;
    endfunction

    // Builds a name that fits the pattern, then sometimes breaks it.
    function automatic t_char_q make_name(t_char_q pat);
        t_char_q nm;
        int      idx;
        foreach (pat[i]) begin
            if (pat[i] == gwm_pkg::CHAR_STAR)
                repeat ($urandom_range(0, 3)) nm.push_back(name_char());
            else if (pat[i] == gwm_pkg::CHAR_ANY) nm.push_back(name_char());
            else nm.push_back(pat[i]);
        end
        if ($urandom_range(0, 2) == 0) begin
            idx = $urandom_range(0, nm.size());
            case ($urandom_range(0, 2))
                0: nm.insert(idx, name_char());
                1: if (idx < nm.size()) nm.delete(idx);
                default: if (idx < nm.size()) nm[idx] = name_char();
            endcase
        end
        return nm;
    endfunction

    function automatic t_char_q noise_name();
        t_char_q nm;
        repeat ($urandom_range(0, 6)) nm.push_back(name_char());
        return nm;
    endfunction

    initial begin : result_sink
        int stall_left;
        stall_left = 0;
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            @(posedge i_clk);
            if (o_out_valid && !i_out_stall) begin
                sb.check_result(o_match, o_pattern_overflow);
                if ($urandom_range(0, 49) == 0) calm_out = !calm_out;
                stall_left = calm_out ? 0 : $urandom_range(0, 4);
            end
            if (hold_req) begin
                stall_left = LONG_HOLD;
                hold_req <= 1'b0;
            end
            i_out_stall <= (stall_left > 0);
            if (stall_left > 0) stall_left--;
        end
    end

    initial begin : watchdog
        int idle;
        idle = 0;
        while (idle < STALL_LIMIT) begin
            @(posedge i_clk);
            if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) idle = 0;
            else idle++;
        end
        $display("glob_wildcard_matcher verification failed");
        $finish;
    end

    initial begin : stimulus
        t_char_q pat;
        t_char_q stored;
        int      blk;
        int      k;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Nothing loaded yet: only the empty name fits.
        send_beat(gwm_pkg::OP_NAME, gwm_pkg::CHAR_END, 1'b1);
        send_beat(gwm_pkg::OP_NAME, "a", 1'b1);
        // Pattern "a*?" closed on its last character.
        send_beat(gwm_pkg::OP_PATTERN, "a", 1'b0);
        send_beat(gwm_pkg::OP_PATTERN, gwm_pkg::CHAR_STAR, 1'b0);
        send_beat(gwm_pkg::OP_PATTERN, gwm_pkg::CHAR_ANY, 1'b1);
        send_beat(gwm_pkg::OP_NAME, "a", 1'b0);
        send_beat(gwm_pkg::OP_NAME, "b", 1'b1);
        send_beat(gwm_pkg::OP_NAME, "a", 1'b0);
        send_beat(gwm_pkg::OP_NAME, gwm_pkg::CHAR_END, 1'b1);
        send_beat(gwm_pkg::OP_NAME, 8'h00, 1'b0);
        send_beat(gwm_pkg::OP_NAME, 8'hFF, 1'b1);
        // Zero byte as a literal, pattern closed by the end marker.
        send_beat(gwm_pkg::OP_PATTERN, 8'h00, 1'b0);
        send_beat(gwm_pkg::OP_PATTERN, 8'hFF, 1'b0);
        send_beat(gwm_pkg::OP_PATTERN, gwm_pkg::CHAR_END, 1'b1);
        send_beat(gwm_pkg::OP_NAME, 8'h00, 1'b0);
        send_beat(gwm_pkg::OP_NAME, 8'hFF, 1'b1);
        // A name in the middle of a load sees only the part stored so far.
        send_beat(gwm_pkg::OP_PATTERN, "x", 1'b0);
        send_beat(gwm_pkg::OP_NAME, "x", 1'b1);
        send_beat(gwm_pkg::OP_PATTERN, gwm_pkg::CHAR_STAR, 1'b1);
        send_beat(gwm_pkg::OP_NAME, "x", 1'b0);
        send_beat(gwm_pkg::OP_NAME, "y", 1'b0);
        send_beat(gwm_pkg::OP_NAME, gwm_pkg::CHAR_END, 1'b1);
        // Empty pattern.
        send_beat(gwm_pkg::OP_PATTERN, gwm_pkg::CHAR_END, 1'b1);
        send_beat(gwm_pkg::OP_NAME, gwm_pkg::CHAR_END, 1'b1);
        send_beat(gwm_pkg::OP_NAME, "b", 1'b1);

        blk = 0;
        while (beats_sent < BEAT_TARGET) begin
            if (blk == 0 || $urandom_range(0, 29) == 0)
                pat = make_pattern($urandom_range(gwm_pkg::CAPACITY + 1,
                                                  gwm_pkg::CAPACITY + 12));
            else
                pat = make_pattern($urandom_range(0, 8));
            if (blk == 2) hold_req <= 1'b1;
            if (blk == 12 || blk == 30) drain_results();
            if (pat.size() > gwm_pkg::CAPACITY) stored = pat[0:gwm_pkg::CAPACITY-1];
            else stored = pat;

            if (pat.size() >= 2 && pat.size() <= gwm_pkg::CAPACITY
                && $urandom_range(0, 9) == 0) begin
                k = $urandom_range(1, pat.size() - 1);
                for (int i = 0; i < k; i++) send_beat(gwm_pkg::OP_PATTERN, pat[i], 1'b0);
                send_seq(gwm_pkg::OP_NAME, make_name(pat[0:k-1]));
                send_seq(gwm_pkg::OP_PATTERN, pat[k:$]);
            end else begin
                send_seq(gwm_pkg::OP_PATTERN, pat);
            end

            repeat (pat.size() > gwm_pkg::CAPACITY ? $urandom_range(1, 2)
                                                   : $urandom_range(1, 6)) begin
                if ($urandom_range(0, 9) == 0) send_seq(gwm_pkg::OP_NAME, noise_name());
                else send_seq(gwm_pkg::OP_NAME, make_name(stored));
            end
            blk++;
        end

        drain_results();
        repeat (SETTLE) @(posedge i_clk);
        $display("Checked %0d name verdicts (%0d matches, %0d under a truncated pattern)",
                 sb.verdicts_seen, sb.match_count, sb.overflow_count);
        $display("from %0d beats, with random gaps, a %0d-cycle output hold and two drains.",
                 beats_sent, LONG_HOLD);
        if (sb.errors == 0 && sb.pending_verdicts.size() == 0) begin
            $display("glob_wildcard_matcher verification clean");
        end else begin
            $display("glob_wildcard_matcher verification failed");
        end
        $finish;
    end

endmodule

>>> glob_wildcard_matcher.f
hw/rtl/gwm_pkg.sv
hw/rtl/gwm_front.sv
hw/rtl/gwm_queue.sv
hw/rtl/gwm_back.sv
hw/rtl/glob_wildcard_matcher.sv
hw/rtl/gwm_checker.sv
test/tb.sv
